/* rtl/hcb_pkg.sv */
// Shared package for the Huffman code builder/encoder.
// Operation and status codes, controller-to-datapath command codes, status struct.
// No dependencies.
package hcb_pkg;

   localparam int DEF_SYMBOLS      = 128;
   localparam int DEF_COUNT_BITS   = 16;
   localparam int DEF_MAX_CODE_LEN = 32;

   localparam logic [1:0] OP_COUNT  = 2'd0;
   localparam logic [1:0] OP_BUILD  = 2'd1;
   localparam logic [1:0] OP_ENCODE = 2'd2;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_EMPTY  = 2'd1;
   localparam logic [1:0] ST_LONG   = 2'd2;
   localparam logic [1:0] ST_NOCODE = 2'd3;

   typedef logic [5:0] hcb_cmd_type;

   localparam hcb_cmd_type C_NOP         = 6'd0;
   localparam hcb_cmd_type C_CAPTURE     = 6'd1;
   localparam hcb_cmd_type C_CNT_RD      = 6'd2;
   localparam hcb_cmd_type C_CNT_WR      = 6'd3;
   localparam hcb_cmd_type C_ENC_RD      = 6'd4;
   localparam hcb_cmd_type C_B_INIT      = 6'd5;
   localparam hcb_cmd_type C_S_RD        = 6'd6;
   localparam hcb_cmd_type C_S_NEXT      = 6'd7;
   localparam hcb_cmd_type C_LEAF        = 6'd8;
   localparam hcb_cmd_type C_INS_PUT     = 6'd9;
   localparam hcb_cmd_type C_INS_RD      = 6'd10;
   localparam hcb_cmd_type C_INS_MOVE    = 6'd11;
   localparam hcb_cmd_type C_B_EMPTY     = 6'd12;
   localparam hcb_cmd_type C_RM_START    = 6'd13;
   localparam hcb_cmd_type C_RM_TOP_A    = 6'd14;
   localparam hcb_cmd_type C_RM_TOP_B    = 6'd15;
   localparam hcb_cmd_type C_RM_RDL      = 6'd16;
   localparam hcb_cmd_type C_RM_RDE      = 6'd17;
   localparam hcb_cmd_type C_RM_BEST_RDR = 6'd18;
   localparam hcb_cmd_type C_RM_BEST     = 6'd19;
   localparam hcb_cmd_type C_RM_CMP      = 6'd20;
   localparam hcb_cmd_type C_RM_MOV      = 6'd21;
   localparam hcb_cmd_type C_RM_FILL     = 6'd22;
   localparam hcb_cmd_type C_M_NODE      = 6'd23;
   localparam hcb_cmd_type C_W_INIT      = 6'd24;
   localparam hcb_cmd_type C_W_ROOT      = 6'd25;
   localparam hcb_cmd_type C_W_RD        = 6'd26;
   localparam hcb_cmd_type C_W_LEAF      = 6'd27;
   localparam hcb_cmd_type C_W_C0        = 6'd28;
   localparam hcb_cmd_type C_W_C1        = 6'd29;
   localparam hcb_cmd_type C_W_END       = 6'd30;
   localparam hcb_cmd_type C_K_DEC       = 6'd31;
   localparam hcb_cmd_type C_RSP_BLD     = 6'd32;
   localparam hcb_cmd_type C_RSP_ENC     = 6'd33;

   typedef struct packed {
      logic s_done;
      logic cnt_zero;
      logic i_top;
      logic ins_stop;
      logic few;
      logic more;
      logic l_in;
      logic r_in;
      logic is_leaf;
      logic k_zero;
      logic rsp_free;
   } hcb_status_type;

endpackage

/* rtl/hcb_ctrl.sv */
// Controller state machine for the Huffman code builder/encoder.
// Sequences count, build (heap insert/remove, tree walk) and encode; uses hcb_pkg.
module hcb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic [1:0]             req_op,
   output logic                   req_tready,
   input  hcb_pkg::hcb_status_type status,
   output hcb_pkg::hcb_cmd_type   cmd
);
   import hcb_pkg::*;

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_CNT_RD  = 5'd1;
   localparam logic [4:0] S_CNT_WR  = 5'd2;
   localparam logic [4:0] S_ENC_RD  = 5'd3;
   localparam logic [4:0] S_ENC_OUT = 5'd4;
   localparam logic [4:0] S_B_INIT  = 5'd5;
   localparam logic [4:0] S_B_SRD   = 5'd6;
   localparam logic [4:0] S_B_SCHK  = 5'd7;
   localparam logic [4:0] S_INS_CHK = 5'd8;
   localparam logic [4:0] S_INS_CMP = 5'd9;
   localparam logic [4:0] S_B_CHK   = 5'd10;
   localparam logic [4:0] S_M_CHK   = 5'd11;
   localparam logic [4:0] S_RM_BEG  = 5'd12;
   localparam logic [4:0] S_RM_TOP  = 5'd13;
   localparam logic [4:0] S_RM_L    = 5'd14;
   localparam logic [4:0] S_RM_L2   = 5'd15;
   localparam logic [4:0] S_RM_CMP  = 5'd16;
   localparam logic [4:0] S_RM_MOV  = 5'd17;
   localparam logic [4:0] S_RM_FILL = 5'd18;
   localparam logic [4:0] S_M_NODE  = 5'd19;
   localparam logic [4:0] S_W_INIT  = 5'd20;
   localparam logic [4:0] S_W_ROOT  = 5'd21;
   localparam logic [4:0] S_W_RD    = 5'd22;
   localparam logic [4:0] S_W_EXE   = 5'd23;
   localparam logic [4:0] S_W_C1    = 5'd24;
   localparam logic [4:0] S_W_NEXT  = 5'd25;
   localparam logic [4:0] S_BLD_OUT = 5'd26;

   logic [4:0] state_ff, state_in;
   logic       rm2_ff, rm2_in;
   logic       ret_ff, ret_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      rm2_in   = rm2_ff;
      ret_in   = ret_ff;
      cmd      = C_NOP;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd = C_CAPTURE;
               case (req_op)
                  OP_COUNT:  state_in = S_CNT_RD;
                  OP_BUILD:  state_in = S_B_INIT;
                  OP_ENCODE: state_in = S_ENC_RD;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_CNT_RD: begin
            cmd = C_CNT_RD;
            state_in = S_CNT_WR;
         end
         S_CNT_WR: begin
            cmd = C_CNT_WR;
            state_in = S_IDLE;
         end
         S_ENC_RD: begin
            cmd = C_ENC_RD;
            state_in = S_ENC_OUT;
         end
         S_ENC_OUT: begin
            if (status.rsp_free) begin
               cmd = C_RSP_ENC;
               state_in = S_IDLE;
            end
         end
         S_B_INIT: begin
            cmd = C_B_INIT;
            state_in = S_B_SRD;
         end
         S_B_SRD: begin
            if (status.s_done) begin
               state_in = S_B_CHK;
            end else begin
               cmd = C_S_RD;
               state_in = S_B_SCHK;
            end
         end
         S_B_SCHK: begin
            if (status.cnt_zero) begin
               cmd = C_S_NEXT;
               state_in = S_B_SRD;
            end else begin
               cmd = C_LEAF;
               ret_in = 1'b0;
               state_in = S_INS_CHK;
            end
         end
         S_INS_CHK: begin
            if (status.i_top) begin
               cmd = C_INS_PUT;
               state_in = ret_ff ? S_M_CHK : S_B_SRD;
            end else begin
               cmd = C_INS_RD;
               state_in = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            if (status.ins_stop) begin
               cmd = C_INS_PUT;
               state_in = ret_ff ? S_M_CHK : S_B_SRD;
            end else begin
               cmd = C_INS_MOVE;
               state_in = S_INS_CHK;
            end
         end
         S_B_CHK: begin
            if (status.few) begin
               cmd = C_B_EMPTY;
               state_in = S_BLD_OUT;
            end else begin
               state_in = S_M_CHK;
            end
         end
         S_M_CHK: begin
            rm2_in = 1'b0;
            state_in = status.more ? S_RM_BEG : S_W_INIT;
         end
         S_RM_BEG: begin
            cmd = C_RM_START;
            state_in = S_RM_TOP;
         end
         S_RM_TOP: begin
            cmd = rm2_ff ? C_RM_TOP_B : C_RM_TOP_A;
            state_in = S_RM_L;
         end
         S_RM_L: begin
            if (status.l_in) begin
               cmd = C_RM_RDL;
               state_in = S_RM_L2;
            end else begin
               cmd = C_RM_RDE;
               state_in = S_RM_FILL;
            end
         end
         S_RM_L2: begin
            if (status.r_in) begin
               cmd = C_RM_BEST_RDR;
               state_in = S_RM_CMP;
            end else begin
               cmd = C_RM_BEST;
               state_in = S_RM_MOV;
            end
         end
         S_RM_CMP: begin
            cmd = C_RM_CMP;
            state_in = S_RM_MOV;
         end
         S_RM_MOV: begin
            cmd = C_RM_MOV;
            state_in = S_RM_L;
         end
         S_RM_FILL: begin
            cmd = C_RM_FILL;
            if (rm2_ff) begin
               state_in = S_M_NODE;
            end else begin
               rm2_in = 1'b1;
               state_in = S_RM_BEG;
            end
         end
         S_M_NODE: begin
            cmd = C_M_NODE;
            ret_in = 1'b1;
            state_in = S_INS_CHK;
         end
         S_W_INIT: begin
            cmd = C_W_INIT;
            state_in = S_W_ROOT;
         end
         S_W_ROOT: begin
            cmd = C_W_ROOT;
            state_in = S_W_RD;
         end
         S_W_RD: begin
            cmd = C_W_RD;
            state_in = S_W_EXE;
         end
         S_W_EXE: begin
            if (status.is_leaf) begin
               cmd = C_W_LEAF;
               state_in = S_W_NEXT;
            end else begin
               cmd = C_W_C0;
               state_in = S_W_C1;
            end
         end
         S_W_C1: begin
            cmd = C_W_C1;
            state_in = S_W_NEXT;
         end
         S_W_NEXT: begin
            if (status.k_zero) begin
               cmd = C_W_END;
               state_in = S_BLD_OUT;
            end else begin
               cmd = C_K_DEC;
               state_in = S_W_RD;
            end
         end
         S_BLD_OUT: begin
            if (status.rsp_free) begin
               cmd = C_RSP_BLD;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rm2_ff   <= 1'b0;
         ret_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         rm2_ff   <= rm2_in;
         ret_ff   <= ret_in;
      end
   end

endmodule

/* rtl/hcb_dp.sv */
// Datapath for the Huffman code builder/encoder: histogram, node, heap,
// walk and code-table memories plus the result register. Uses hcb_pkg.
module hcb_dp #(
   parameter int SYMBOLS      = hcb_pkg::DEF_SYMBOLS,
   parameter int COUNT_BITS   = hcb_pkg::DEF_COUNT_BITS,
   parameter int MAX_CODE_LEN = hcb_pkg::DEF_MAX_CODE_LEN
) (
   input  logic                    clock,
   input  logic                    reset,
   input  hcb_pkg::hcb_cmd_type    cmd,
   input  logic [6:0]              req_symbol,
   output hcb_pkg::hcb_status_type status,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [39:0]             rsp_tdata
);
   import hcb_pkg::*;

   localparam int NODE_CAP = 2 * SYMBOLS;
   localparam int HEAP_CAP = SYMBOLS + 2;
   localparam int SAW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
   localparam int NAW = $clog2(NODE_CAP);
   localparam int HAW = $clog2(HEAP_CAP);
   localparam int HIW = $clog2(2 * HEAP_CAP + 1);
   localparam int WW  = COUNT_BITS + SAW;
   localparam int EW  = WW + NAW;
   localparam int LW  = $clog2(MAX_CODE_LEN + 1);
   localparam int MW  = MAX_CODE_LEN;
   localparam int NEW = 1 + SAW + 2 * NAW;
   localparam int DEW = NAW + MW;
   localparam int CEW = LW + MW;
   localparam logic [COUNT_BITS-1:0] LIMIT = {COUNT_BITS{1'b1}};

   // memories
   logic [COUNT_BITS-1:0] cnt_mem [SYMBOLS];
   logic [SYMBOLS-1:0]    cnt_vld_ff;
   logic [NEW-1:0]        node_mem [NODE_CAP];
   logic [DEW-1:0]        dc_mem [NODE_CAP];
   logic [EW-1:0]         hp_mem [HEAP_CAP];
   logic [CEW-1:0]        ct_mem [SYMBOLS];
   logic [SYMBOLS-1:0]    ct_vld_ff, ct_vld_in;

   logic [COUNT_BITS-1:0] cnt_rd_ff;
   logic                  cnt_rdv_ff;
   logic [NEW-1:0]        node_rd_ff;
   logic [DEW-1:0]        dc_rd_ff;
   logic [EW-1:0]         hp_rd_ff;
   logic [CEW-1:0]        ct_rd_ff;
   logic                  ct_rdv_ff;

   logic                  cnt_re, cnt_we;
   logic [SAW-1:0]        cnt_raddr, cnt_waddr;
   logic [COUNT_BITS-1:0] cnt_wdata;
   logic                  node_re, node_we;
   logic [NAW-1:0]        node_waddr;
   logic [NEW-1:0]        node_wdata;
   logic                  dc_we;
   logic [NAW-1:0]        dc_waddr;
   logic [DEW-1:0]        dc_wdata;
   logic                  hp_re, hp_we;
   logic [HAW-1:0]        hp_raddr, hp_waddr;
   logic [EW-1:0]         hp_wdata;
   logic                  ct_re, ct_we;
   logic [SAW-1:0]        ct_waddr;
   logic [CEW-1:0]        ct_wdata;

   // scalar registers
   logic [6:0]     sym_ff, sym_in;
   logic [SAW:0]   s_ff, s_in;
   logic [HIW-1:0] end_ff, end_in, i_ff, i_in, l_ff, l_in, bidx_ff, bidx_in;
   logic [NAW-1:0] ncnt_ff, ncnt_in, k_ff, k_in;
   logic [EW-1:0]  newe_ff, newe_in, a_ff, a_in, b_ff, b_in, best_ff, best_in;
   logic           long_ff, long_in;
   logic [1:0]     res_ff, res_in;
   logic           rv_ff, rv_in;
   logic [39:0]    rd_ff, rd_in;

   logic                  sym_ok;
   logic [SAW-1:0]        sym_addr;
   logic [COUNT_BITS-1:0] cnt_val;
   logic [HIW-1:0]        l_calc, r_idx;
   logic                  nd_leaf;
   logic [SAW-1:0]        nd_sym;
   logic [NAW-1:0]        nd_left, nd_right, dc_depth, ch_depth;
   logic [MW-1:0]         dc_code, ch_code;
   logic                  rsp_free;

   assign sym_ok   = 32'(sym_ff) < 32'(SYMBOLS);
   assign sym_addr = SAW'(sym_ff);
   assign cnt_val  = cnt_rdv_ff ? cnt_rd_ff : '0;
   assign l_calc   = i_ff << 1;
   assign r_idx    = l_ff + HIW'(1);
   assign nd_leaf  = node_rd_ff[NEW-1];
   assign nd_sym   = node_rd_ff[2*NAW +: SAW];
   assign nd_left  = node_rd_ff[NAW +: NAW];
   assign nd_right = node_rd_ff[0 +: NAW];
   assign dc_depth = dc_rd_ff[MW +: NAW];
   assign dc_code  = dc_rd_ff[0 +: MW];
   assign ch_depth = dc_depth + NAW'(1);
   assign ch_code  = dc_code << 1;
   assign rsp_free = !rv_ff || rsp_tready;

   assign status.s_done   = (s_ff == (SAW + 1)'(SYMBOLS));
   assign status.cnt_zero = (cnt_val == '0);
   assign status.i_top    = ((i_ff >> 1) == '0);
   assign status.ins_stop = (hp_rd_ff[EW-1:NAW] <= newe_ff[EW-1:NAW]);
   assign status.few      = (end_ff < HIW'(2));
   assign status.more     = (end_ff > HIW'(2));
   assign status.l_in     = (l_calc < end_ff);
   assign status.r_in     = (r_idx < end_ff);
   assign status.is_leaf  = nd_leaf;
   assign status.k_zero   = (k_ff == '0);
   assign status.rsp_free = rsp_free;

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_ff;

   always_comb begin
      cnt_re = 1'b0; cnt_we = 1'b0; cnt_raddr = sym_addr; cnt_waddr = sym_addr;
      cnt_wdata = cnt_val + COUNT_BITS'(1);
      node_re = 1'b0; node_we = 1'b0; node_waddr = ncnt_ff; node_wdata = '0;
      dc_we = 1'b0; dc_waddr = nd_left; dc_wdata = {ch_depth, ch_code};
      hp_re = 1'b0; hp_we = 1'b0; hp_raddr = HAW'(1); hp_waddr = i_ff[HAW-1:0];
      hp_wdata = newe_ff;
      ct_re = 1'b0; ct_we = 1'b0; ct_waddr = nd_sym;
      ct_wdata = {LW'(dc_depth), dc_code};
      ct_vld_in = ct_vld_ff;
      sym_in = sym_ff; s_in = s_ff; end_in = end_ff; i_in = i_ff; l_in = l_ff;
      bidx_in = bidx_ff; ncnt_in = ncnt_ff; k_in = k_ff; newe_in = newe_ff;
      a_in = a_ff; b_in = b_ff; best_in = best_ff; long_in = long_ff; res_in = res_ff;
      rv_in = rv_ff && !rsp_tready; rd_in = rd_ff;
      case (cmd)
         C_CAPTURE: sym_in = req_symbol;
         C_CNT_RD:  cnt_re = 1'b1;
         C_CNT_WR:  cnt_we = sym_ok && (cnt_val != LIMIT);
         C_ENC_RD:  ct_re = 1'b1;
         C_B_INIT: begin
            end_in = HIW'(1); ncnt_in = '0; s_in = '0; ct_vld_in = '0; long_in = 1'b0;
         end
         C_S_RD: begin
            cnt_re = 1'b1;
            cnt_raddr = s_ff[SAW-1:0];
         end
         C_S_NEXT: s_in = s_ff + (SAW + 1)'(1);
         C_LEAF: begin
            node_we = 1'b1;
            node_wdata = {1'b1, s_ff[SAW-1:0], {(2*NAW){1'b0}}};
            newe_in = {WW'(cnt_val), ncnt_ff};
            ncnt_in = ncnt_ff + NAW'(1);
            s_in = s_ff + (SAW + 1)'(1);
            i_in = end_ff;
            end_in = end_ff + HIW'(1);
         end
         C_INS_PUT: hp_we = 1'b1;
         C_INS_RD: begin
            hp_re = 1'b1;
            hp_raddr = HAW'(i_ff >> 1);
         end
         C_INS_MOVE: begin
            hp_we = 1'b1;
            hp_wdata = hp_rd_ff;
            i_in = i_ff >> 1;
         end
         C_B_EMPTY: res_in = ST_EMPTY;
         C_RM_START: begin
            hp_re = 1'b1;
            end_in = end_ff - HIW'(1);
            i_in = HIW'(1);
         end
         C_RM_TOP_A: a_in = hp_rd_ff;
         C_RM_TOP_B: b_in = hp_rd_ff;
         C_RM_RDL: begin
            hp_re = 1'b1;
            hp_raddr = l_calc[HAW-1:0];
            l_in = l_calc;
         end
         C_RM_RDE: begin
            hp_re = 1'b1;
            hp_raddr = end_ff[HAW-1:0];
         end
         C_RM_BEST_RDR: begin
            best_in = hp_rd_ff;
            bidx_in = l_ff;
            hp_re = 1'b1;
            hp_raddr = r_idx[HAW-1:0];
         end
         C_RM_BEST: begin
            best_in = hp_rd_ff;
            bidx_in = l_ff;
         end
         C_RM_CMP: begin
            if (hp_rd_ff[EW-1:NAW] < best_ff[EW-1:NAW]) begin
               best_in = hp_rd_ff;
               bidx_in = r_idx;
            end
         end
         C_RM_MOV: begin
            hp_we = 1'b1;
            hp_wdata = best_ff;
            i_in = bidx_ff;
         end
         C_RM_FILL: begin
            hp_we = 1'b1;
            hp_wdata = hp_rd_ff;
         end
         C_M_NODE: begin
            node_we = 1'b1;
            node_wdata = {1'b0, {SAW{1'b0}}, a_ff[NAW-1:0], b_ff[NAW-1:0]};
            newe_in = {a_ff[EW-1:NAW] + b_ff[EW-1:NAW], ncnt_ff};
            ncnt_in = ncnt_ff + NAW'(1);
            i_in = end_ff;
            end_in = end_ff + HIW'(1);
         end
         C_W_INIT: hp_re = 1'b1;
         C_W_ROOT: begin
            k_in = hp_rd_ff[NAW-1:0];
            dc_we = 1'b1;
            dc_waddr = hp_rd_ff[NAW-1:0];
            dc_wdata = '0;
         end
         C_W_RD: node_re = 1'b1;
         C_W_LEAF: begin
            if (32'(dc_depth) > 32'(MAX_CODE_LEN)) long_in = 1'b1;
            ct_we = 1'b1;
            ct_vld_in[nd_sym] = 1'b1;
         end
         C_W_C0: dc_we = 1'b1;
         C_W_C1: begin
            dc_we = 1'b1;
            dc_waddr = nd_right;
            dc_wdata = {ch_depth, ch_code | MW'(1)};
         end
         C_W_END: begin
            if (long_ff) begin
               ct_vld_in = '0;
               res_in = ST_LONG;
            end else begin
               res_in = ST_OK;
            end
         end
         C_K_DEC: k_in = k_ff - NAW'(1);
         C_RSP_BLD: begin
            rv_in = 1'b1;
            rd_in = {res_ff, 6'd0, 32'd0};
         end
         C_RSP_ENC: begin
            rv_in = 1'b1;
            if (ct_rdv_ff) begin
               rd_in = {ST_OK, 6'(ct_rd_ff[MW +: LW]), 32'(ct_rd_ff[0 +: MW])};
            end else begin
               rd_in = {ST_NOCODE, 6'd0, 32'd0};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
      if (cnt_re) begin
         cnt_rd_ff  <= cnt_mem[cnt_raddr];
         cnt_rdv_ff <= cnt_vld_ff[cnt_raddr];
      end
      if (node_we) node_mem[node_waddr] <= node_wdata;
      if (node_re) begin
         node_rd_ff <= node_mem[k_ff];
         dc_rd_ff   <= dc_mem[k_ff];
      end
      if (dc_we) dc_mem[dc_waddr] <= dc_wdata;
      if (hp_we) hp_mem[hp_waddr] <= hp_wdata;
      if (hp_re) hp_rd_ff <= hp_mem[hp_raddr];
      if (ct_we) ct_mem[ct_waddr] <= ct_wdata;
      if (ct_re) begin
         ct_rd_ff  <= ct_mem[sym_addr];
         ct_rdv_ff <= ct_vld_ff[sym_addr] && sym_ok;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff  <= sym_in;
      s_ff    <= s_in;
      end_ff  <= end_in;
      i_ff    <= i_in;
      l_ff    <= l_in;
      bidx_ff <= bidx_in;
      ncnt_ff <= ncnt_in;
      k_ff    <= k_in;
      newe_ff <= newe_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      best_ff <= best_in;
      long_ff <= long_in;
      res_ff  <= res_in;
      rd_ff   <= rd_in;
      if (reset) begin
         cnt_vld_ff <= '0;
         ct_vld_ff  <= '0;
         rv_ff      <= 1'b0;
      end else begin
         if (cnt_we) cnt_vld_ff[cnt_waddr] <= 1'b1;
         ct_vld_ff <= ct_vld_in;
         rv_ff     <= rv_in;
      end
   end

endmodule

/* rtl/huffman_code_builder_encoder_top.sv */
// Huffman code builder/encoder: 7-bit symbol histogram, heap-based tree build, code lookup.
// Top level joining hcb_ctrl and hcb_dp; uses hcb_pkg.
//
// A count transaction reads and then writes the histogram and produces no response; an encode
// reads the code table, then registers its response once the response slot is free. A build
// runs as one sequence of memory steps: the symbol scan, heap inserts and removals level by
// level, then the code walk over the tree nodes; inputs stall meanwhile. The pace is set by
// the single-port heap and node memories with registered reads. A pending response holds a
// finished build or encode until it is taken.
module huffman_code_builder_encoder_top #(
   parameter int SYMBOLS      = hcb_pkg::DEF_SYMBOLS,
   parameter int COUNT_BITS   = hcb_pkg::DEF_COUNT_BITS,
   parameter int MAX_CODE_LEN = hcb_pkg::DEF_MAX_CODE_LEN
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [1:0] op, [8:2] symbol, [15:9] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [31:0] code_bits, [37:32] code_length, [39:38] status
);
   import hcb_pkg::*;

   hcb_cmd_type    cmd;
   hcb_status_type status;

   hcb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tdata[1:0]),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   hcb_dp #(
      .SYMBOLS      (SYMBOLS),
      .COUNT_BITS   (COUNT_BITS),
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_symbol (req_tdata[8:2]),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
